// ===== src/satt_pkg.sv =====
// Shared types and constants for the set-associative transposition table.
// Used by every module in src but satt_ram; depends on nothing else.
package satt_pkg;

    // BUCKETS must be a power of two: the bucket is taken from the low key bits.
    localparam int BUCKETS   = 1024;
    localparam int WAYS      = 4;
    localparam int TOTAL     = BUCKETS * WAYS;
    localparam int ADDR_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KEY_W     = 64;
    localparam int INFO_W    = 50;
    localparam int ENTRY_W   = KEY_W + INFO_W;
    localparam int MATE_EDGE = 28000;

    typedef enum logic [1:0] {
        FUNC_PROBE = 2'd0,
        FUNC_STORE = 2'd1,
        FUNC_AGE   = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    typedef struct packed {
        func_t              func;
        logic [63:0]        key;
        logic [6:0]         depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [6:0]         ply;
        logic signed [15:0] new_score;
        logic [1:0]         bound;
        logic [5:0]         move_from;
        logic [5:0]         move_to;
        logic [3:0]         move_flag;
    } req_t;

    typedef struct packed {
        logic               entry_found;
        logic               cutoff;
        logic signed [15:0] found_score;
        logic [5:0]         best_from;
        logic [5:0]         best_to;
        logic [3:0]         best_flag;
        logic               move_valid;
    } rsp_t;

    typedef struct packed {
        logic [3:0]         move_flag;
        logic [5:0]         move_to;
        logic [5:0]         move_from;
        logic [7:0]         age;
        logic [1:0]         bound;
        logic signed [15:0] score;
        logic signed [7:0]  depth;
    } info_t;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic signed [9:0]  quality;
        logic               replace;
        logic               refresh;
        logic               cut;
        logic signed [15:0] score;
    } eval_t;

endpackage

// ===== src/satt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module satt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/satt_bucket_mod.sv =====
// Bucket select: the key modulo the bucket count, registered in the cycle after start.
// Depends on satt_pkg; the bucket count is a power of two, so this is a mask.
module satt_bucket_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [satt_pkg::BKT_W-1:0] key,
    output logic                       done,
    output logic [satt_pkg::BKT_W-1:0] bucket
);
    import satt_pkg::*;

    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic              done_reg, done_next;

    always_comb
    begin
        bucket_next = bucket_reg;
        done_next   = start;
        if (start)
        begin
            bucket_next = (BUCKETS > 1) ? key : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bucket_reg <= bucket_next;
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;
endmodule

// ===== src/satt_way_eval.sv =====
// Evaluates a stored way for a request: match, quality, replace, refresh, cutoff.
// Depends on satt_pkg.
module satt_way_eval (
    input  logic [satt_pkg::KEY_W-1:0] entry_key,
    input  satt_pkg::info_t            info,
    input  satt_pkg::req_t             req,
    input  logic [7:0]                 age,
    output satt_pkg::eval_t            ev
);
    import satt_pkg::*;

    logic [7:0]         delta;
    logic signed [15:0] s;
    logic signed [15:0] ply_s;
    logic               depth_ok;
    logic signed [9:0]  q;

    always_comb
    begin
        ply_s    = $signed({9'b0, req.ply});
        delta    = age - info.age;
        depth_ok = info.depth >= $signed({1'b0, req.depth});
        if (info.score >= 16'sd28000)
        begin
            s = info.score - ply_s;
        end
        else if (info.score <= -16'sd28000)
        begin
            s = info.score + ply_s;
        end
        else
        begin
            s = info.score;
        end

        q = $signed({info.depth[7], info.depth, 1'b0});
        if (info.bound == BOUND_EXACT)
        begin
            q = q + 10'sd3;
        end
        if (delta == 8'd0)
        begin
            q = q + 10'sd8;
        end
        else if (delta == 8'd1)
        begin
            q = q + 10'sd2;
        end
        else
        begin
            q = q - 10'sd2;
        end

        ev.valid   = !info.depth[7];
        ev.hit     = ev.valid && (entry_key == req.key);
        ev.quality = q;
        ev.score   = s;
        ev.replace = ($signed({1'b0, req.depth}) >= info.depth)
                     || (req.bound == BOUND_EXACT) || (info.age != age);
        ev.refresh = (req.move_from != 6'd0) || (req.move_to != 6'd0);
        ev.cut     = depth_ok && ((info.bound == BOUND_EXACT)
                     || (info.bound == BOUND_LOWER && s >= req.beta)
                     || (info.bound == BOUND_UPPER && s <= req.alpha));
    end
endmodule

// ===== src/set_assoc_transposition_table_top.sv =====
// Top level of the set-associative transposition table: sequencer, table RAM
// and age counter. Depends on satt_pkg, satt_ram, satt_bucket_mod, satt_way_eval.
//
// After reset the block sweeps the table once, one entry per cycle (4096 entries),
// and accepts no request until the sweep ends. A probe or store then goes through
// the accept state, the bucket-select state, a scan of the ways in turn through
// the single evaluation unit (the RAM read of the next way overlaps), a write-back
// state for a store that writes, and the result state. A new-search or unused
// request goes from the accept state straight to the result state. One request is
// in flight at a time; the next is taken once the result has been accepted.
module set_assoc_transposition_table_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  satt_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output satt_pkg::rsp_t   rsp
);
    import satt_pkg::*;

    typedef enum logic [5:0] {
        ST_CLR  = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_MOD  = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_WR   = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [WAY_W-1:0]    way_reg, way_next;
    logic [7:0]          age_reg, age_next;
    req_t                req_reg, req_next;
    logic signed [15:0]  ts_reg, ts_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   worst_reg, worst_next;
    logic signed [9:0]   worst_q_reg, worst_q_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [ENTRY_W-1:0]  wr_data_reg, wr_data_next;
    rsp_t                rsp_reg, rsp_next;

    logic                mod_start;
    logic                mod_done;
    logic [BKT_W-1:0]    bucket;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    info_t               cur_info;
    eval_t               ev;
    logic                last_way;
    logic [ADDR_W-1:0]   cur_addr;
    logic signed [16:0]  ts_sum;
    info_t               new_info;
    info_t               ref_info;
    info_t               empty_info;

    satt_bucket_mod u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .key    (req.key[BKT_W-1:0]),
        .done   (mod_done),
        .bucket (bucket)
    );

    satt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_info = info_t'(ram_rdata[INFO_W-1:0]);

    satt_way_eval u_eval (
        .entry_key (ram_rdata[ENTRY_W-1:INFO_W]),
        .info      (cur_info),
        .req       (req_reg),
        .age       (age_reg),
        .ev        (ev)
    );

    assign last_way  = (way_reg == WAY_W'(WAYS - 1));
    assign cur_addr  = base_reg + ADDR_W'(way_reg);
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

    always_comb
    begin
        empty_info       = '0;
        empty_info.depth = -8'sd1;

        new_info           = '0;
        new_info.depth     = $signed({1'b0, req_reg.depth});
        new_info.score     = ts_reg;
        new_info.bound     = req_reg.bound;
        new_info.age       = age_reg;
        new_info.move_from = req_reg.move_from;
        new_info.move_to   = req_reg.move_to;
        new_info.move_flag = req_reg.move_flag;

        ref_info           = cur_info;
        ref_info.age       = age_reg;
        ref_info.move_from = req_reg.move_from;
        ref_info.move_to   = req_reg.move_to;
        ref_info.move_flag = req_reg.move_flag;

        ts_sum = 17'(req.new_score);
        if (req.new_score >= 16'sd28000)
        begin
            ts_sum = 17'(req.new_score) + $signed({10'b0, req.ply});
        end
        else if (req.new_score <= -16'sd28000)
        begin
            ts_sum = 17'(req.new_score) - $signed({10'b0, req.ply});
        end
    end

    always_comb
    begin
        info_t keep_info;
        logic  take_worst;

        state_next   = state_reg;
        clr_next     = clr_reg;
        way_next     = way_reg;
        age_next     = age_reg;
        req_next     = req_reg;
        ts_next      = ts_reg;
        base_next    = base_reg;
        worst_next   = worst_reg;
        worst_q_next = worst_q_reg;
        wr_addr_next = wr_addr_reg;
        wr_data_next = wr_data_reg;
        rsp_next     = rsp_reg;
        mod_start    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = wr_addr_reg;
        ram_wdata    = wr_data_reg;
        ram_raddr    = base_reg;

        keep_info = new_info;
        if ({req_reg.move_flag, req_reg.move_to, req_reg.move_from} == 16'd0)
        begin
            keep_info.move_from = cur_info.move_from;
            keep_info.move_to   = cur_info.move_to;
            keep_info.move_flag = cur_info.move_flag;
        end
        take_worst = (way_reg == '0) || (ev.quality < worst_q_reg);

        case (state_reg)
            ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {{KEY_W{1'b0}}, empty_info};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TOTAL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    rsp_next = '0;
                    if (ts_sum > 17'sd32767)
                    begin
                        ts_next = 16'sd32767;
                    end
                    else if (ts_sum < -17'sd32768)
                    begin
                        ts_next = -16'sd32768;
                    end
                    else
                    begin
                        ts_next = ts_sum[15:0];
                    end
                    case (req.func)
                        FUNC_PROBE, FUNC_STORE:
                        begin
                            mod_start  = 1'b1;
                            state_next = ST_MOD;
                        end
                        FUNC_AGE:
                        begin
                            age_next   = age_reg + 8'd1;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                base_next = ADDR_W'(bucket * WAYS);
                ram_raddr = base_next;
                if (mod_done)
                begin
                    way_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_raddr = last_way ? base_reg : (cur_addr + 1'b1);
                way_next  = way_reg + 1'b1;
                if (req_reg.func == FUNC_PROBE)
                begin
                    if (ev.hit)
                    begin
                        rsp_next.entry_found = 1'b1;
                        rsp_next.cutoff      = ev.cut;
                        rsp_next.found_score = ev.score;
                        rsp_next.best_from   = cur_info.move_from;
                        rsp_next.best_to     = cur_info.move_to;
                        rsp_next.best_flag   = cur_info.move_flag;
                        rsp_next.move_valid  = ({cur_info.move_flag, cur_info.move_to,
                                                 cur_info.move_from} != 16'd0);
                        state_next = ST_DONE;
                    end
                    else if (last_way)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (ev.hit)
                begin
                    wr_addr_next = cur_addr;
                    if (ev.replace)
                    begin
                        wr_data_next = {req_reg.key, keep_info};
                        state_next   = ST_WR;
                    end
                    else if (ev.refresh)
                    begin
                        wr_data_next = {req_reg.key, ref_info};
                        state_next   = ST_WR;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (!ev.valid)
                begin
                    wr_addr_next = cur_addr;
                    wr_data_next = {req_reg.key, new_info};
                    state_next   = ST_WR;
                end
                else
                begin
                    if (take_worst)
                    begin
                        worst_next   = cur_addr;
                        worst_q_next = ev.quality;
                    end
                    if (last_way)
                    begin
                        wr_addr_next = take_worst ? cur_addr : worst_reg;
                        wr_data_next = {req_reg.key, new_info};
                        state_next   = ST_WR;
                    end
                end
            end
            ST_WR:
            begin
                ram_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            way_reg   <= '0;
            age_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            way_reg   <= way_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        ts_reg      <= ts_next;
        base_reg    <= base_next;
        worst_reg   <= worst_next;
        worst_q_reg <= worst_q_next;
        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= wr_data_next;
        rsp_reg     <= rsp_next;
    end

`ifndef SYNTH
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request accepted while a result is pending");

    a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.func == FUNC_AGE) |=>
        (age_reg == $past(age_reg) + 8'd1))
        else $error("search age did not advance");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |->
        (ADDR_W'(wr_addr_reg - base_reg) < ADDR_W'(WAYS)))
        else $error("write-back outside the selected bucket");
`endif
endmodule

// ===== verif/set_assoc_transposition_table_top_test.sv =====
// Self-checking testbench for the set-associative transposition table.
// Drives random and directed probe, store, new-search and unused requests and checks
// every response against an in-bench model. Depends on satt_pkg and the top.
`timescale 1ns / 1ps

module set_assoc_transposition_table_top_test;
    import satt_pkg::*;

    localparam int  NUM_RANDOM = 1000;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    set_assoc_transposition_table_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Table shadow.
    logic [63:0] tbl_key [TOTAL];
    info_t       tbl_info [TOTAL];
    logic [7:0]  cur_age;

    req_t  pending_reqs [$];
    rsp_t  expected_rsps [$];
    int    errors = 0;
    int    probe_hits = 0;
    int    cutoffs = 0;
    int    responses = 0;
    bit    stim_done = 1'b0;
    bit    hold_for_drain = 1'b0;
    bit    drain_done = 1'b0;
    longint cycles = 0;

    function automatic int entry_quality(info_t e);
        int q;
        logic [7:0] d;
        q = int'(e.depth) * 2;
        d = cur_age - e.age;
        if (e.bound == BOUND_EXACT)
            q += 3;
        q += (d == 8'd0) ? 8 : ((d == 8'd1) ? 2 : -2);
        return q;
    endfunction

    function automatic int clip16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Applies one request to the shadow table and returns its response.
    function automatic rsp_t lookup_or_update(req_t r);
        rsp_t o;
        int base, idx, worst, dst, s, ts;
        bit cut, have_empty;
        info_t e;
        logic [15:0] mv;
        o = '0;
        base = int'(r.key % BUCKETS) * WAYS;
        mv = {r.move_flag, r.move_to, r.move_from};
        if (r.func == FUNC_AGE)
            cur_age = cur_age + 8'd1;
        else if (r.func == FUNC_PROBE)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                e = tbl_info[base + w];
                if (e.depth >= 0 && tbl_key[base + w] == r.key)
                begin
                    s = int'(e.score);
                    if (s >= MATE_EDGE)
                        s -= int'(r.ply);
                    else if (s <= -MATE_EDGE)
                        s += int'(r.ply);
                    cut = 1'b0;
                    if (int'(e.depth) >= int'(r.depth))
                    begin
                        if (e.bound == BOUND_EXACT)
                            cut = 1'b1;
                        else if (e.bound == BOUND_LOWER && s >= int'(r.beta))
                            cut = 1'b1;
                        else if (e.bound == BOUND_UPPER && s <= int'(r.alpha))
                            cut = 1'b1;
                    end
                    o.entry_found = 1'b1;
                    o.cutoff = cut;
                    o.found_score = s[15:0];
                    o.best_from = e.move_from;
                    o.best_to = e.move_to;
                    o.best_flag = e.move_flag;
                    o.move_valid = ({e.move_flag, e.move_to, e.move_from} != 16'd0);
                    break;
                end
            end
        end
        else if (r.func == FUNC_STORE)
        begin
            ts = int'(r.new_score);
            if (ts >= MATE_EDGE)
                ts = clip16(ts + int'(r.ply));
            else if (ts <= -MATE_EDGE)
                ts = clip16(ts - int'(r.ply));
            worst = base;
            have_empty = 1'b0;
            dst = base;
            for (int w = 0; w < WAYS; w++)
            begin
                idx = base + w;
                e = tbl_info[idx];
                if (e.depth >= 0 && tbl_key[idx] == r.key)
                begin
                    if (int'(r.depth) >= int'(e.depth) || r.bound == BOUND_EXACT
                        || e.age != cur_age)
                    begin
                        if (mv == 16'd0)
                            mv = {e.move_flag, e.move_to, e.move_from};
                        tbl_info[idx] = {mv, cur_age, r.bound, ts[15:0],
                                         1'b0, r.depth};
                    end
                    else if (r.move_from != 6'd0 || r.move_to != 6'd0)
                        tbl_info[idx] = {mv, cur_age, e.bound, e.score, e.depth};
                    return o;
                end
                if (e.depth < 0)
                begin
                    have_empty = 1'b1;
                    dst = idx;
                    break;
                end
                if (entry_quality(e) < entry_quality(tbl_info[worst]))
                    worst = idx;
            end
            if (!have_empty)
                dst = worst;
            tbl_key[dst] = r.key;
            tbl_info[dst] = {mv, cur_age, r.bound, ts[15:0], 1'b0, r.depth};
        end
        return o;
    endfunction

    // Keys drawn from a few buckets so ways fill up and get replaced.
    logic [63:0] key_pool [16];

    function automatic req_t random_request();
        req_t r;
        int sel;
        r = '0;
        sel = $urandom_range(99);
        r.func = (sel < 45) ? FUNC_PROBE : (sel < 92) ? FUNC_STORE
               : (sel < 98) ? FUNC_AGE : FUNC_NONE;
        r.key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
              : key_pool[$urandom_range(15)];
        r.depth = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(12));
        r.alpha = 16'($urandom);
        r.beta = 16'($urandom);
        if ($urandom_range(1))
        begin
            r.alpha = 16'($urandom_range(400)) - 16'd200;
            r.beta = 16'($urandom_range(400)) - 16'd200;
        end
        r.ply = 7'($urandom);
        case ($urandom_range(3))
            0: r.new_score = 16'($urandom);
            1: r.new_score = 16'(28000 + $urandom_range(4767));
            2: r.new_score = -16'(28000 + $urandom_range(4768));
            default: r.new_score = 16'($urandom_range(400)) - 16'd200;
        endcase
        r.bound = 2'($urandom);
        if ($urandom_range(3) != 0)
        begin
            r.move_from = 6'($urandom);
            r.move_to = 6'($urandom);
            r.move_flag = 4'($urandom);
        end
        else if ($urandom_range(1))
            r.move_flag = 4'($urandom);
        return r;
    endfunction

    function automatic req_t make_req(func_t f, logic [63:0] k, int d, int sc,
                                      logic [1:0] b, int pl);
        req_t r;
        r = '0;
        r.func = f;
        r.key = k;
        r.depth = 7'(d);
        r.new_score = 16'(sc);
        r.bound = b;
        r.ply = 7'(pl);
        r.alpha = 16'sd0;
        r.beta = 16'sd0;
        r.move_from = 6'd12;
        r.move_to = 6'd28;
        r.move_flag = 4'd0;
        return r;
    endfunction

    initial
    begin
        req_t r;
        for (int i = 0; i < TOTAL; i++)
        begin
            tbl_key[i] = '0;
            tbl_info[i] = '0;
            tbl_info[i].depth = -8'sd1;
        end
        cur_age = '0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = (64'({$urandom, $urandom}) << 6) + 64'(i % 3);

        // Directed: key zero on an empty table, extremes, mate scores, bounds.
        pending_reqs.push_back(make_req(FUNC_PROBE, 64'd0, 0, 0, BOUND_EXACT, 0));
        pending_reqs.push_back(make_req(FUNC_STORE, 64'd0, 127, 32767, BOUND_EXACT, 127));
        pending_reqs.push_back(make_req(FUNC_PROBE, 64'd0, 127, 0, BOUND_EXACT, 127));
        pending_reqs.push_back(make_req(FUNC_STORE, '1, 0, -32768, BOUND_LOWER, 127));
        r = make_req(FUNC_PROBE, '1, 0, 0, BOUND_EXACT, 5);
        r.beta = 16'sh8000;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(FUNC_STORE, 64'd1024, 5, 28000, BOUND_UPPER, 3));
        r = make_req(FUNC_PROBE, 64'd1024, 6, 0, BOUND_EXACT, 3);
        pending_reqs.push_back(r);
        r.depth = 7'd5;
        r.alpha = 16'sd32767;
        pending_reqs.push_back(r);
        // Fill bucket 0 past its ways to force a replacement, and bound code 3.
        pending_reqs.push_back(make_req(FUNC_STORE, 64'd2048, 3, -27999, 2'd3, 0));
        pending_reqs.push_back(make_req(FUNC_STORE, 64'd3072, 1, 100, BOUND_LOWER, 0));
        pending_reqs.push_back(make_req(FUNC_AGE, 64'd0, 0, 0, BOUND_EXACT, 0));
        pending_reqs.push_back(make_req(FUNC_STORE, 64'd4096, 2, 7, BOUND_UPPER, 0));
        pending_reqs.push_back(make_req(FUNC_PROBE, 64'd2048, 0, 0, BOUND_EXACT, 0));
        // Shallower non-exact store on a current entry: only the move refreshes.
        r = make_req(FUNC_STORE, 64'd4096, 1, 9, BOUND_LOWER, 0);
        r.move_from = 6'd63; r.move_to = 6'd63; r.move_flag = 4'd15;
        pending_reqs.push_back(r);
        r = make_req(FUNC_STORE, 64'd4096, 9, 9, BOUND_LOWER, 0);
        r.move_from = 6'd0; r.move_to = 6'd0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(FUNC_PROBE, 64'd4096, 0, 0, BOUND_EXACT, 0));
        pending_reqs.push_back(make_req(FUNC_NONE, '1, 127, -1, 2'd3, 127));
        pending_reqs.push_back(make_req(FUNC_PROBE, '1, 0, 0, BOUND_EXACT, 0));

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            pending_reqs.push_back(random_request());
            // Sweep the age through its wrap in a few long runs.
            if (i == 300 || i == 700)
                for (int a = 0; a < 256; a++)
                    pending_reqs.push_back(make_req(FUNC_AGE, 64'd0, 0, 0,
                                                    BOUND_EXACT, 0));
        end
    end

    // Request driver: bursts and gaps, with one full drain partway through.
    int burst_left = 0;
    int gap_left = 0;
    int sent = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(lookup_or_update(req));
                sent <= sent + 1;
            end
            if (req_valid && req_stall)
                ;
            else if (pending_reqs.size() == 0)
            begin
                req_valid <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (hold_for_drain)
            begin
                req_valid <= 1'b0;
                if (expected_rsps.size() == 0)
                    hold_for_drain <= 1'b0;
            end
            else if (sent >= 700 && !drain_done)
            begin
                req_valid <= 1'b0;
                hold_for_drain <= 1'b1;
                drain_done <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                req_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                req_valid <= 1'b1;
                req <= pending_reqs.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(12);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(20);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Response monitor and stall pattern.
    int stall_phase = 0;

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            stall_phase <= (stall_phase + 1) % 512;
            if (stall_phase < 128)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(2) == 0);
            if (rsp_valid && !rsp_stall)
            begin
                responses <= responses + 1;
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response %p", rsp);
                    errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (want.entry_found) probe_hits++;
                    if (want.cutoff) cutoffs++;
                    if (rsp.entry_found !== want.entry_found)
                    begin
                        $error("entry_found expected %0d got %0d",
                               want.entry_found, rsp.entry_found);
                        errors++;
                    end
                    if (rsp.cutoff !== want.cutoff)
                    begin
                        $error("cutoff expected %0d got %0d", want.cutoff, rsp.cutoff);
                        errors++;
                    end
                    if (rsp.found_score !== want.found_score)
                    begin
                        $error("found_score expected %0d got %0d",
                               want.found_score, rsp.found_score);
                        errors++;
                    end
                    if (rsp.best_from !== want.best_from)
                    begin
                        $error("best_from expected %0d got %0d",
                               want.best_from, rsp.best_from);
                        errors++;
                    end
                    if (rsp.best_to !== want.best_to)
                    begin
                        $error("best_to expected %0d got %0d", want.best_to, rsp.best_to);
                        errors++;
                    end
                    if (rsp.best_flag !== want.best_flag)
                    begin
                        $error("best_flag expected %0d got %0d",
                               want.best_flag, rsp.best_flag);
                        errors++;
                    end
                    if (rsp.move_valid !== want.move_valid)
                    begin
                        $error("move_valid expected %0d got %0d",
                               want.move_valid, rsp.move_valid);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && expected_rsps.size() == 0) && cycles < CYCLE_LIMIT)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
            $display("set_assoc_transposition_table_top_test: done, errors");
        else
        begin
            $display("Covered %0d responses: %0d probe hits, %0d cutoffs.",
                     responses, probe_hits, cutoffs);
            if (errors == 0 && expected_rsps.size() == 0)
                $display("set_assoc_transposition_table_top_test: done, clean");
            else
                $display("set_assoc_transposition_table_top_test: done, errors");
        end
        $finish;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

endmodule
